// ===== hdl/cfdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfdsa_pkg: shared types and constants of the crc frame deframer
// Frame markers, length limits, result codes and the byte-wise crc-16 update.
// ----------------------------------------------------------------------------
package cfdsa_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int CHANNELS     = 16;

  // position and length counters only need to reach BUFFER_BYTES - 1
  localparam int LEN_W = $clog2(BUFFER_BYTES);

  localparam logic [7:0] HDR_BYTE     = 8'h5A;
  localparam logic [7:0] TAIL_BYTE    = 8'hA5;
  localparam logic [7:0] FUNC_STATUS  = 8'h8F;
  localparam logic [7:0] SUB_STATUS   = 8'h03;
  localparam logic [7:0] SUB_SET_A    = 8'h42;
  localparam logic [7:0] SUB_SET_B    = 8'h62;

  localparam logic [15:0] LEN_MIN  = 16'd7;
  localparam logic [15:0] LEN_MAX  = 16'(BUFFER_BYTES - 4);
  localparam logic [15:0] CH_MASK  = 16'((33'h1 << CHANNELS) - 33'h1);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // fixed byte positions inside a frame
  localparam logic [LEN_W-1:0] POS_FUNC   = LEN_W'(5);
  localparam logic [LEN_W-1:0] POS_SUB    = LEN_W'(6);
  localparam logic [LEN_W-1:0] POS_ST_LO  = LEN_W'(7);
  localparam logic [LEN_W-1:0] POS_ST_HI  = LEN_W'(8);
  localparam logic [LEN_W-1:0] POS_BODY   = LEN_W'(4);

  // register index (bit 2 of the byte address)
  localparam logic REG_PROBE = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    RC_STATUS = 3'd0,
    RC_SET    = 3'd1,
    RC_OTHER  = 3'd2,
    RC_LEN    = 3'd3,
    RC_TAIL   = 3'd4,
    RC_CRC    = 3'd5
  } res_code_t;

  typedef struct packed {
    res_code_t   code;
    logic [7:0]  subcode;
    logic [15:0] status;
    logic        alarm;
    logic [15:0] frame_bytes;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfdsa_parser.sv =====
// ----------------------------------------------------------------------------
// cfdsa_parser: byte-serial frame parser
// Holds the parse state, runs the crc and checks length, crc and tail on each
// accepted byte; flags a result in the same cycle as the byte.
// ----------------------------------------------------------------------------
module cfdsa_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                probe_engaged,
  output logic                res_valid,
  output cfdsa_pkg::result_t  res
);
  import cfdsa_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       rcrc_r, rcrc_nxt;
  logic [7:0]        func_r, func_nxt;
  logic [7:0]        sub_r, sub_nxt;
  logic [15:0]       status_r, status_nxt;

  logic [15:0]       len_full;
  logic [15:0]       len16;
  logic [15:0]       crc_upd;
  logic              len_bad;
  logic              tail1_pos;
  logic              last_pos;

  assign len_full  = {rx_byte, len_lo_r};
  assign len16     = 16'(len_r);
  assign crc_upd   = crc16_byte(crc_r, rx_byte);
  assign len_bad   = (len_full < LEN_MIN) || (len_full > LEN_MAX);
  assign tail1_pos = (pos_r == len_r + LEN_W'(2));
  assign last_pos  = (pos_r > len_r + LEN_W'(2));

  // next state and datapath
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    len_lo_nxt = len_lo_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    func_nxt   = func_r;
    sub_nxt    = sub_r;
    status_nxt = status_r;
    case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == HDR_BYTE) begin
          phase_nxt = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (rx_byte == HDR_BYTE) begin
          phase_nxt = PH_LEN_LO;
          crc_nxt   = CRC_INIT;
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_LEN_LO: begin
        len_lo_nxt = rx_byte;
        crc_nxt    = crc_upd;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_nxt = crc_upd;
        len_nxt = len_full[LEN_W-1:0];
        if (len_bad) begin
          phase_nxt = PH_HUNT1;
        end else begin
          phase_nxt = PH_BODY;
          pos_nxt   = POS_BODY;
        end
      end
      PH_BODY: begin
        pos_nxt = pos_r + LEN_W'(1);
        if (pos_r == POS_ST_LO) begin
          status_nxt[7:0] = rx_byte;
        end else if (pos_r == POS_ST_HI) begin
          status_nxt[15:8] = rx_byte;
        end
        if (pos_r < len_r) begin
          crc_nxt = crc_upd;
          if (pos_r == POS_FUNC) begin
            func_nxt = rx_byte;
          end else if (pos_r == POS_SUB) begin
            sub_nxt = rx_byte;
          end
        end else if (pos_r == len_r) begin
          rcrc_nxt[7:0] = rx_byte;
        end else if (pos_r == len_r + LEN_W'(1)) begin
          rcrc_nxt[15:8] = rx_byte;
        end else if (tail1_pos) begin
          if (rx_byte != TAIL_BYTE) begin
            phase_nxt = PH_HUNT1;
          end
        end else begin
          // last tail byte: frame is complete either way
          phase_nxt = PH_HUNT1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  // result for the current byte
  always_comb begin
    res_valid = 1'b0;
    res       = '{code: RC_OTHER, subcode: 8'h00, status: 16'h0000,
                  alarm: 1'b0, frame_bytes: 16'h0000};
    case (phase_r)
      PH_LEN_HI: begin
        if (len_bad) begin
          res_valid       = 1'b1;
          res.code        = RC_LEN;
          res.frame_bytes = 16'd4;
        end
      end
      PH_BODY: begin
        if (tail1_pos && rx_byte != TAIL_BYTE) begin
          res_valid       = 1'b1;
          res.code        = RC_TAIL;
          res.frame_bytes = len16 + 16'd3;
        end else if (last_pos) begin
          res_valid       = 1'b1;
          res.frame_bytes = len16 + 16'd4;
          if (rx_byte != TAIL_BYTE) begin
            res.code = RC_TAIL;
          end else if (rcrc_r != crc_r) begin
            res.code = RC_CRC;
          end else if (func_r == FUNC_STATUS && sub_r == SUB_STATUS) begin
            res.code    = RC_STATUS;
            res.subcode = sub_r;
            res.status  = status_r;
            res.alarm   = ((status_r & CH_MASK) != 16'h0000) && probe_engaged;
          end else if (func_r == FUNC_STATUS && (sub_r == SUB_SET_A || sub_r == SUB_SET_B)) begin
            res.code    = RC_SET;
            res.subcode = sub_r;
          end else begin
            res.code    = RC_OTHER;
            res.subcode = sub_r;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r    <= len_nxt;
      len_lo_r <= len_lo_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
      func_r   <= func_nxt;
      sub_r    <= sub_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== hdl/crc_frame_deframer_status_alarm.sv =====
// ----------------------------------------------------------------------------
// crc_frame_deframer_status_alarm: link byte deframer with crc-16 check
// Parses framed bytes, checks length, crc and tail, reports status and alarm.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one received byte per transfer (in_tdata[7:0]).
//   out_*  : one result per completed frame or detected error; nothing is
//            sent for dropped hunt bytes or bytes inside a frame.
//   cfg_*  : apb register 0 (address 0), bit 0 = probe_engaged.
//   Throughput is one byte per cycle while in_tready is high: the parse step
//   and the byte-wise crc update sit between the parse state registers and the
//   result register. The result for the byte that ends the frame is registered
//   into the output register (out_tvalid) as that byte is accepted, unless stalled.
//   When the receiver stalls, one extra result is held in a skid register;
//   in_tready drops only while that register is occupied.
//   Reset (rst_n low, synchronous) returns the parser to hunting the first
//   header byte, empties the output and clears probe_engaged.
// ----------------------------------------------------------------------------
module crc_frame_deframer_status_alarm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] reply_subcode, [23:8] channel_status,
                                   // [24] raise_alarm, [40:25] frame_bytes, rest 0
  output logic [2:0]  out_tuser,   // [2:0] result_code
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cfdsa_pkg::*;

  logic    probe_r;
  logic    in_accept;
  logic    p_valid;
  result_t p_res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_r, skid_nxt;
  logic    out_load;
  logic    new_res;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'h0, probe_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_PROBE) begin
      probe_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  cfdsa_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_accept),
    .rx_byte       (in_tdata),
    .probe_engaged (probe_r),
    .res_valid     (p_valid),
    .res           (p_res)
  );

  // output register plus skid slot
  assign out_load = !out_valid_r || out_tready;
  assign new_res  = in_accept && p_valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_load) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      if (out_load) begin
        out_valid_nxt = 1'b1;
        out_nxt       = p_res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = p_res;
      end
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.code;
  assign out_tdata  = {7'h00, out_r.frame_bytes, out_r.alarm, out_r.status, out_r.subcode};

  // skid slot is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  // a stalled output fills the skid only from a new result
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && out_valid_r && !out_tready && !new_res) |=> !skid_valid_r)
    else $error("skid filled without a new result");

  // alarm only on a nonzero status reply
  a_alarm_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.alarm) |-> (out_r.code == RC_STATUS && out_r.status != 16'h0000))
    else $error("alarm raised outside a nonzero status reply");

  // length errors are always found on the last byte of the length field
  a_len_err_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.code == RC_LEN) |-> (out_r.frame_bytes == 16'd4 &&
                                               out_r.subcode == 8'h00))
    else $error("length error with wrong byte count");

endmodule

// ===== tb/crc_frame_deframer_status_alarm_test.sv =====
// ----------------------------------------------------------------------------
// crc_frame_deframer_status_alarm_test: byte deframer with crc-16 and alarm
// Feeds framed byte streams (good frames, bad crc, bad tail, bad length and
// header noise) and checks every result against the bench's cycle-free deframer
// model or a typed directed row, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module crc_frame_deframer_status_alarm_test;
  import cfdsa_pkg::*;

  typedef enum {FLT_NONE, FLT_CRC, FLT_TAIL1, FLT_TAIL2, FLT_CRC_TAIL} fault_t;

  typedef struct {
    int unsigned len;
    logic [7:0]  func;
    logic [7:0]  sub;
    logic [15:0] word;
    fault_t      flt;
    bit          noisy;
    bit          typed;
    res_code_t   want_code;
    logic [15:0] want_bytes;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;      // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;     // [7:0] subcode, [23:8] status, [24] alarm, [40:25] bytes
  logic [2:0]  out_tuser;     // [2:0] result_code
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // deframer model state
  phase_t      parse_st;
  logic [15:0] decl_len;
  logic [15:0] pos;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic [15:0] st_word;
  logic [7:0]  func_b;
  logic [7:0]  sub_b;
  logic        probe_en;

  result_t     pending_replies[$];
  int          fail_count;
  int          bytes_in;
  int          frames_sent;
  int          replies_seen;
  int          code_seen[6];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  bit          typed_on;
  res_code_t   typed_code;
  logic [15:0] typed_bytes;

  dir_row_t dir_rows[17] = '{
    '{9,    FUNC_STATUS, SUB_STATUS, 16'h0000, FLT_NONE,     1, 0, RC_STATUS, 16'd0},
    '{9,    FUNC_STATUS, SUB_STATUS, 16'hFFFF, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{7,    FUNC_STATUS, SUB_STATUS, 16'h1234, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{8,    FUNC_STATUS, SUB_SET_A,  16'h00FF, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{12,   FUNC_STATUS, SUB_SET_B,  16'hFF00, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{9,    8'h00,       SUB_STATUS, 16'h0001, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{9,    FUNC_STATUS, 8'hFF,      16'h8000, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{9,    FUNC_STATUS, SUB_STATUS, 16'h0001, FLT_CRC,      0, 1, RC_CRC,    16'd13},
    '{9,    FUNC_STATUS, SUB_STATUS, 16'h0001, FLT_TAIL1,    1, 1, RC_TAIL,   16'd12},
    '{9,    FUNC_STATUS, SUB_STATUS, 16'h0001, FLT_TAIL2,    0, 1, RC_TAIL,   16'd13},
    '{9,    FUNC_STATUS, SUB_STATUS, 16'h0001, FLT_CRC_TAIL, 0, 1, RC_TAIL,   16'd13},
    '{6,    FUNC_STATUS, SUB_STATUS, 16'h0000, FLT_NONE,     0, 1, RC_LEN,    16'd4},
    '{0,    FUNC_STATUS, SUB_STATUS, 16'h0000, FLT_NONE,     0, 1, RC_LEN,    16'd4},
    '{1021, FUNC_STATUS, SUB_STATUS, 16'h0000, FLT_NONE,     0, 1, RC_LEN,    16'd4},
    '{65535, FUNC_STATUS, SUB_STATUS, 16'h0000, FLT_NONE,    0, 1, RC_LEN,    16'd4},
    '{60,   FUNC_STATUS, SUB_STATUS, 16'h8001, FLT_NONE,     0, 0, RC_STATUS, 16'd0},
    '{7,    FUNC_STATUS, SUB_SET_A,  16'h0000, FLT_NONE,     1, 0, RC_STATUS, 16'd0}
  };

  crc_frame_deframer_status_alarm uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) begin
      c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic result_t pack_result(input res_code_t code, input logic [7:0] sub,
                                          input logic [15:0] word, input logic alarm,
                                          input logic [15:0] nbytes);
    result_t r;
    r.code        = code;
    r.subcode     = sub;
    r.status      = word;
    r.alarm       = alarm;
    r.frame_bytes = nbytes;
    return r;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == x) v = ~x;
    return v;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // one byte through the deframer model; hit is set when a result comes out
  task automatic deframe_byte(input logic [7:0] b, output bit hit, output result_t r);
    int unsigned len;
    int unsigned p;
    len = decl_len;
    p   = pos;
    hit = 1'b0;
    r   = '0;
    case (parse_st)
      PH_HUNT1: begin
        if (b == HDR_BYTE) parse_st = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == HDR_BYTE) begin
          parse_st = PH_LEN_LO;
          crc_acc  = CRC_INIT;
        end else begin
          parse_st = PH_HUNT1;
          pos      = '0;
        end
      end
      PH_LEN_LO: begin
        decl_len = {8'h00, b};
        crc_acc  = crc16_step(crc_acc, b);
        parse_st = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        decl_len[15:8] = b;
        crc_acc        = crc16_step(crc_acc, b);
        len            = decl_len;
        if (len < LEN_MIN || len + 4 > BUFFER_BYTES) begin
          hit      = 1'b1;
          r        = pack_result(RC_LEN, 8'h00, 16'h0000, 1'b0, 16'd4);
          parse_st = PH_HUNT1;
          pos      = '0;
        end else begin
          parse_st = PH_BODY;
          pos      = 16'd4;
        end
      end
      PH_BODY: begin
        // status bytes are taken by position, even when they are crc bytes
        if (p == POS_ST_LO) st_word[7:0] = b;
        else if (p == POS_ST_HI) st_word[15:8] = b;
        if (p < len) begin
          crc_acc = crc16_step(crc_acc, b);
          if (p == POS_FUNC) func_b = b;
          else if (p == POS_SUB) sub_b = b;
          pos = 16'(p + 1);
        end else if (p == len) begin
          crc_rx = {8'h00, b};
          pos    = 16'(p + 1);
        end else if (p == len + 1) begin
          crc_rx[15:8] = b;
          pos          = 16'(p + 1);
        end else if (p == len + 2) begin
          if (b != TAIL_BYTE) begin
            hit      = 1'b1;
            r        = pack_result(RC_TAIL, 8'h00, 16'h0000, 1'b0, 16'(len + 3));
            parse_st = PH_HUNT1;
            pos      = '0;
          end else begin
            pos = 16'(p + 1);
          end
        end else begin
          hit      = 1'b1;
          parse_st = PH_HUNT1;
          pos      = '0;
          if (b != TAIL_BYTE)
            r = pack_result(RC_TAIL, 8'h00, 16'h0000, 1'b0, 16'(len + 4));
          else if (crc_rx != crc_acc)
            r = pack_result(RC_CRC, 8'h00, 16'h0000, 1'b0, 16'(len + 4));
          else if (func_b == FUNC_STATUS && sub_b == SUB_STATUS)
            r = pack_result(RC_STATUS, sub_b, st_word,
                            ((st_word & CH_MASK) != 16'h0000) && probe_en, 16'(len + 4));
          else if (func_b == FUNC_STATUS && (sub_b == SUB_SET_A || sub_b == SUB_SET_B))
            r = pack_result(RC_SET, sub_b, 16'h0000, 1'b0, 16'(len + 4));
          else
            r = pack_result(RC_OTHER, sub_b, 16'h0000, 1'b0, 16'(len + 4));
        end
      end
      default: begin
        parse_st = PH_HUNT1;
        pos      = '0;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit      hit;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(posedge clk);
    end while (!in_tready);
    bytes_in++;
    deframe_byte(b, hit, r);
    if (hit) begin
      if (typed_on) r = pack_result(typed_code, 8'h00, 16'h0000, 1'b0, typed_bytes);
      pending_replies.push_back(r);
    end
  endtask

  // frame: 5a 5a len_lo len_hi, payload up to len-1, crc lo/hi, a5 a5
  task automatic send_frame(input int unsigned len, input logic [7:0] func,
                            input logic [7:0] sub, input logic [15:0] word,
                            input fault_t flt, input bit noisy);
    logic [7:0]  q[$];
    logic [7:0]  b;
    logic [15:0] crc;
    if (noisy) q = {8'h00, 8'hFF, other_than(HDR_BYTE), HDR_BYTE, other_than(HDR_BYTE)};
    q.push_back(HDR_BYTE);
    q.push_back(HDR_BYTE);
    q.push_back(8'(len));
    q.push_back(8'(len >> 8));
    if (len >= LEN_MIN && len + 4 <= BUFFER_BYTES) begin
      crc = crc16_step(crc16_step(CRC_INIT, 8'(len)), 8'(len >> 8));
      for (int unsigned p = 4; p < len; p++) begin
        case (p)
          5:       b = func;
          6:       b = sub;
          7:       b = word[7:0];
          8:       b = word[15:8];
          default: b = 8'($urandom);
        endcase
        crc = crc16_step(crc, b);
        q.push_back(b);
      end
      if (flt == FLT_CRC || flt == FLT_CRC_TAIL) crc = crc ^ (16'h0001 << $urandom_range(15));
      q.push_back(crc[7:0]);
      q.push_back(crc[15:8]);
      if (flt == FLT_TAIL1) begin
        q.push_back(other_than(TAIL_BYTE));
      end else begin
        q.push_back(TAIL_BYTE);
        q.push_back((flt == FLT_TAIL2 || flt == FLT_CRC_TAIL) ? other_than(TAIL_BYTE)
                                                              : TAIL_BYTE);
      end
    end
    frames_sent++;
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic random_frame();
    int unsigned len;
    int          r;
    logic [7:0]  func;
    logic [7:0]  sub;
    logic [15:0] word;
    fault_t      flt;
    r = $urandom_range(99);
    if (r < 8)
      len = $urandom_range(1) ? $urandom_range(6) : $urandom_range(65535, BUFFER_BYTES - 3);
    else if (r < 12)
      len = $urandom_range(120, 25);
    else
      len = $urandom_range(20, 7);
    func = ($urandom_range(99) < 75) ? FUNC_STATUS : 8'($urandom);
    case ($urandom_range(3))
      0:       sub = SUB_STATUS;
      1:       sub = SUB_SET_A;
      2:       sub = SUB_SET_B;
      default: sub = 8'($urandom);
    endcase
    word = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
    r = $urandom_range(99);
    if (r < 62)      flt = FLT_NONE;
    else if (r < 72) flt = FLT_CRC;
    else if (r < 80) flt = FLT_TAIL1;
    else if (r < 88) flt = FLT_TAIL2;
    else if (r < 92) flt = FLT_CRC_TAIL;
    else             flt = FLT_NONE;
    send_frame(len, func, sub, word, flt, $urandom_range(99) < 15);
  endtask

  // hold the input until every expected result is out, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_PROBE, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    probe_en = v[0];
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    if (cfg_prdata[0] !== probe_en)
      report($sformatf("probe_engaged read %0b want %0b", cfg_prdata[0], probe_en));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input logic [31:0] probe_word);
    int start_bytes;
    int nframes;
    wait_idle();
    cfg_write(probe_word);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes    = bytes_in;
    nframes        = 0;
    while (bytes_in - start_bytes < 80 || nframes < 4) begin
      random_frame();
      nframes++;
      if ($urandom_range(99) < 5) wait_idle();
    end
  endtask

  task automatic check_reply();
    result_t want;
    if (out_tuser <= RC_CRC) code_seen[out_tuser]++;
    replies_seen++;
    if (pending_replies.size() == 0) begin
      report($sformatf("result code %0d with nothing expected", out_tuser));
    end else begin
      want = pending_replies.pop_front();
      if (out_tuser !== want.code)
        report($sformatf("result_code got %0d want %0d", out_tuser, want.code));
      if (out_tdata[7:0] !== want.subcode)
        report($sformatf("reply_subcode got %0h want %0h", out_tdata[7:0], want.subcode));
      if (out_tdata[23:8] !== want.status)
        report($sformatf("channel_status got %0h want %0h", out_tdata[23:8], want.status));
      if (out_tdata[24] !== want.alarm)
        report($sformatf("raise_alarm got %0b want %0b", out_tdata[24], want.alarm));
      if (out_tdata[40:25] !== want.frame_bytes)
        report($sformatf("frame_bytes got %0d want %0d", out_tdata[40:25], want.frame_bytes));
    end
  endtask

  // result side: check each transfer, then pick the next ready
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_reply();
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    parse_st       = PH_HUNT1;
    decl_len       = '0;
    pos            = '0;
    crc_acc        = CRC_INIT;
    crc_rx         = '0;
    st_word        = '0;
    func_b         = '0;
    sub_b          = '0;
    probe_en       = 1'b0;
    fail_count     = 0;
    bytes_in       = 0;
    frames_sent    = 0;
    replies_seen   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    typed_on       = 1'b0;
    typed_code     = RC_STATUS;
    typed_bytes    = '0;
    foreach (code_seen[i]) code_seen[i] = 0;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(32'hFFFF_FFFE);
    foreach (dir_rows[i]) begin
      typed_on    = dir_rows[i].typed;
      typed_code  = dir_rows[i].want_code;
      typed_bytes = dir_rows[i].want_bytes;
      send_frame(dir_rows[i].len, dir_rows[i].func, dir_rows[i].sub, dir_rows[i].word,
                 dir_rows[i].flt, dir_rows[i].noisy);
    end
    typed_on = 1'b0;

    run_phase(0, 0, 32'hFFFF_FFFF);
    run_phase(82, 0, 32'h0000_0000);
    run_phase(0, 82, 32'h0000_0001);
    run_phase(18, 18, 32'hFFFF_FFFF);

    // long receiver hold-off while short frames keep coming: input must stall
    wait_idle();
    cfg_write(32'h0000_0000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 150;
    repeat (10) begin
      send_frame($urandom_range(10, 7), FUNC_STATUS, SUB_STATUS, 16'($urandom), FLT_NONE, 0);
    end
    wait_idle();

    if (pending_replies.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_replies.size()));
    $display("sent %0d bytes in %0d frames, checked %0d results", bytes_in, frames_sent,
             replies_seen);
    $display("by code: status %0d, set ack %0d, other %0d, length %0d, tail %0d, crc %0d",
             code_seen[RC_STATUS], code_seen[RC_SET], code_seen[RC_OTHER], code_seen[RC_LEN],
             code_seen[RC_TAIL], code_seen[RC_CRC]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
